FILE: design/imrof_pkg.sv
package imrof_pkg;

    localparam int CHROM_W = 5;
    localparam int POS_W   = 32;
    localparam int LEN_W   = 10;

    // action codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // load status codes
    localparam logic [2:0] ST_APPEND = 3'd0;
    localparam logic [2:0] ST_EXTEND = 3'd1;
    localparam logic [2:0] ST_ABSORB = 3'd2;
    localparam logic [2:0] ST_ORDER  = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;

    // query verdict codes
    localparam logic [1:0] V_OUT     = 2'd0;
    localparam logic [1:0] V_IN      = 2'd1;
    localparam logic [1:0] V_UNKNOWN = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_LCHK,
        S_BS,
        S_BSCHK,
        S_SRD,
        S_SCHK,
        S_FIN
    } seq_state_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [2:0] load_status;
    } result_t;

endpackage

FILE: design/island_merge_and_read_overlap_filter_unit.sv
// One item at a time. A load reads and checks the last island of its list; a query runs a
// binary search of p probes (at most ceil(log2(n+1)), 11 for 1024 islands), steps back one
// island and scans k islands (usually 1 or 2). Both go straight to the result when the list is
// empty or the id is out of range. Each probe is one island memory read followed by a compare.
// Result sits in an output register, so the next word is taken while it waits. Reset (rst_n,
// async low) clears all island counts, not the memory.
module island_merge_and_read_overlap_filter_unit #(
    parameter int CHROMS            = 32,
    parameter int ISLANDS_PER_CHROM = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [4:0] chrom_id, [36:5] position_start, [68:37] island_end, [78:69] read_length, [79] 0
    input  logic [79:0] s_axis_tdata,
    // [0] action
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] load_status, [4:3] verdict, [7:5] 0
    output logic [7:0]  m_axis_tdata
);

    import imrof_pkg::*;

    // only ids 0..31 can arrive, so at most 32 lists are kept
    localparam int NC    = (CHROMS < 32) ? CHROMS : 32;
    localparam int CIW   = (NC > 1) ? $clog2(NC) : 1;
    localparam int IDX_W = $clog2(ISLANDS_PER_CHROM);
    localparam int CNT_W = $clog2(ISLANDS_PER_CHROM + 1);
    localparam int AW    = CIW + IDX_W;
    localparam int DEPTH = NC << IDX_W;

    logic [CIW-1:0]   cnt_rd_idx;
    logic [CNT_W-1:0] cnt_rd_data;
    logic             cnt_wr_en;
    logic [CIW-1:0]   cnt_wr_idx;
    logic [CNT_W-1:0] cnt_wr_data;
    logic             mem_rd_en;
    logic [AW-1:0]    mem_rd_addr;
    logic [63:0]      mem_rd_data;
    logic             mem_wr_en;
    logic [AW-1:0]    mem_wr_addr;
    logic [63:0]      mem_wr_data;
    logic             res_valid;
    logic             res_ready;
    result_t          res;

    logic             out_valid_reg;
    result_t          out_data_reg;

    // island memory: one 64-bit word per island, end in the upper half
    imrof_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (64)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // per-chromosome island counts, cleared by reset
    imrof_cnt #(
        .NC    (NC),
        .CIW   (CIW),
        .CNT_W (CNT_W)
    ) u_cnt (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (cnt_rd_idx),
        .rd_data (cnt_rd_data),
        .wr_en   (cnt_wr_en),
        .wr_idx  (cnt_wr_idx),
        .wr_data (cnt_wr_data)
    );

    // load merge / query search sequencer
    imrof_seq #(
        .CHROMS            (CHROMS),
        .ISLANDS_PER_CHROM (ISLANDS_PER_CHROM)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .action         (s_axis_tuser),
        .chrom_id       (s_axis_tdata[4:0]),
        .position_start (s_axis_tdata[36:5]),
        .island_end     (s_axis_tdata[68:37]),
        .read_length    (s_axis_tdata[78:69]),
        .cnt_rd_idx     (cnt_rd_idx),
        .cnt_rd_data    (cnt_rd_data),
        .cnt_wr_en      (cnt_wr_en),
        .cnt_wr_idx     (cnt_wr_idx),
        .cnt_wr_data    (cnt_wr_data),
        .mem_rd_en      (mem_rd_en),
        .mem_rd_addr    (mem_rd_addr),
        .mem_rd_data    (mem_rd_data),
        .mem_wr_en      (mem_wr_en),
        .mem_wr_addr    (mem_wr_addr),
        .mem_wr_data    (mem_wr_data),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res)
    );

    // output word register: free when empty or being taken this cycle
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_data_reg.verdict, out_data_reg.load_status};

    // a load never carries a verdict and a query never carries a status
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] == ST_APPEND || m_axis_tdata[4:3] == V_OUT))
        else $error("status and verdict both set");

    // codes stay in range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] != 3'd5 && m_axis_tdata[2:0] != 3'd6
                           && m_axis_tdata[2:0] != 3'd7 && m_axis_tdata[4:3] != 2'd3))
        else $error("result code out of range");

    // one word in flight: sequencer is busy right after taking a word
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("word taken while busy");

    // the table and memory are never written in the same cycle as a memory read
    a_rw: assert property (@(posedge clk) disable iff (!rst_n)
        mem_rd_en |-> !mem_wr_en && !cnt_wr_en)
        else $error("read and write overlap");

endmodule

FILE: design/imrof_mem.sv
module imrof_mem #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15,
    parameter int DW    = 64
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/imrof_cnt.sv
module imrof_cnt #(
    parameter int NC    = 32,
    parameter int CIW   = 5,
    parameter int CNT_W = 11
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CIW-1:0]   rd_idx,
    output logic [CNT_W-1:0] rd_data,
    input  logic             wr_en,
    input  logic [CIW-1:0]   wr_idx,
    input  logic [CNT_W-1:0] wr_data
);

    logic [CNT_W-1:0] cnt_reg [NC];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NC; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            cnt_reg[wr_idx] <= wr_data;
        end
    end

    // ids past the table read as empty
    always_comb
    begin
        rd_data = '0;
        if (32'(rd_idx) < NC)
        begin
            rd_data = cnt_reg[rd_idx];
        end
    end

endmodule

FILE: design/imrof_seq.sv
module imrof_seq #(
    parameter int CHROMS            = 32,
    parameter int ISLANDS_PER_CHROM = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 action,
    input  logic [4:0]           chrom_id,
    input  logic [31:0]          position_start,
    input  logic [31:0]          island_end,
    input  logic [9:0]           read_length,
    output logic [((CHROMS < 32) ? ((CHROMS > 1) ? $clog2(CHROMS) : 1) : 5)-1:0] cnt_rd_idx,
    input  logic [$clog2(ISLANDS_PER_CHROM + 1)-1:0] cnt_rd_data,
    output logic                 cnt_wr_en,
    output logic [((CHROMS < 32) ? ((CHROMS > 1) ? $clog2(CHROMS) : 1) : 5)-1:0] cnt_wr_idx,
    output logic [$clog2(ISLANDS_PER_CHROM + 1)-1:0] cnt_wr_data,
    output logic                 mem_rd_en,
    output logic [((CHROMS < 32) ? ((CHROMS > 1) ? $clog2(CHROMS) : 1) : 5)
                  + $clog2(ISLANDS_PER_CHROM)-1:0] mem_rd_addr,
    input  logic [63:0]          mem_rd_data,
    output logic                 mem_wr_en,
    output logic [((CHROMS < 32) ? ((CHROMS > 1) ? $clog2(CHROMS) : 1) : 5)
                  + $clog2(ISLANDS_PER_CHROM)-1:0] mem_wr_addr,
    output logic [63:0]          mem_wr_data,
    output logic                 res_valid,
    input  logic                 res_ready,
    output imrof_pkg::result_t   res
);

    import imrof_pkg::*;

    localparam int NC    = (CHROMS < 32) ? CHROMS : 32;
    localparam int CIW   = (NC > 1) ? $clog2(NC) : 1;
    localparam int IDX_W = $clog2(ISLANDS_PER_CHROM);
    localparam int CNT_W = $clog2(ISLANDS_PER_CHROM + 1);

    seq_state_t       state_reg, state_next;
    logic             act_reg;
    logic             ok_reg;
    logic [CIW-1:0]   cidx_reg;
    logic [31:0]      pos_reg;
    logic [31:0]      iend_reg;
    logic [9:0]       rlen_reg;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    result_t          res_reg, res_next;

    logic [CNT_W-1:0] n_m1;
    logic [CNT_W-1:0] mid_calc;
    logic [31:0]      rd_start, rd_end;
    logic             in_fire;
    logic             chrom_ok;
    logic             last_above;
    logic             gap_after;
    logic             end_beyond;
    logic             hit;
    logic             read_before;
    logic             is_full;

    assign in_fire    = in_valid && (state_reg == S_IDLE);
    assign chrom_ok   = 32'(chrom_id) < NC;
    assign cnt_rd_idx = chrom_id[CIW-1:0];
    assign n_m1       = n_reg - CNT_W'(1);
    assign mid_calc   = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rd_start   = mem_rd_data[31:0];
    assign rd_end     = mem_rd_data[63:32];
    assign is_full    = n_reg >= CNT_W'(ISLANDS_PER_CHROM);

    // 33-bit compares so end + 1 and start + len never wrap
    assign last_above  = rd_start > pos_reg;
    assign gap_after   = ({1'b0, rd_end} + 33'd1) < {1'b0, pos_reg};
    assign end_beyond  = rd_end < iend_reg;
    assign hit         = (({1'b0, pos_reg} + 33'(rlen_reg)) >= {1'b0, rd_start})
                      && ({1'b0, pos_reg} <= ({1'b0, rd_end} + 33'(rlen_reg)));
    assign read_before = pos_reg < rd_start;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (!ok_reg || n_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else if (act_reg == ACT_LOAD)
                begin
                    state_next = S_LCHK;
                end
                else
                begin
                    state_next = S_BS;
                end
            end
            S_LCHK:  state_next = S_FIN;
            S_BS:
            begin
                state_next = (lo_reg < hi_reg) ? S_BSCHK : S_SRD;
            end
            S_BSCHK: state_next = S_BS;
            S_SRD:
            begin
                state_next = (lo_reg < n_reg) ? S_SCHK : S_FIN;
            end
            S_SCHK:
            begin
                state_next = (hit || read_before) ? S_FIN : S_SRD;
            end
            S_FIN:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // search bounds and result
    always_comb
    begin
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        mid_next = mid_reg;
        res_next = res_reg;
        case (state_reg)
            S_START:
            begin
                lo_next  = '0;
                hi_next  = n_reg;
                res_next = '0;
                if (act_reg == ACT_LOAD)
                begin
                    if (!ok_reg)
                    begin
                        res_next.load_status = ST_FULL;
                    end
                    else
                    begin
                        res_next.load_status = ST_APPEND;
                    end
                end
                else
                begin
                    res_next.verdict = V_UNKNOWN;
                end
            end
            S_LCHK:
            begin
                if (last_above)
                begin
                    res_next.load_status = ST_ORDER;
                end
                else if (gap_after)
                begin
                    res_next.load_status = is_full ? ST_FULL : ST_APPEND;
                end
                else if (end_beyond)
                begin
                    res_next.load_status = ST_EXTEND;
                end
                else
                begin
                    res_next.load_status = ST_ABSORB;
                end
            end
            S_BS:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next = mid_calc;
                end
                else if (lo_reg != '0)
                begin
                    // step back one island
                    lo_next = lo_reg - CNT_W'(1);
                end
            end
            S_BSCHK:
            begin
                if (rd_start < pos_reg)
                begin
                    lo_next = mid_reg + CNT_W'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
            end
            S_SRD:
            begin
                if (lo_reg >= n_reg)
                begin
                    res_next.verdict = V_OUT;
                end
            end
            S_SCHK:
            begin
                if (hit)
                begin
                    res_next.verdict = V_IN;
                end
                else if (read_before)
                begin
                    res_next.verdict = V_OUT;
                end
                else
                begin
                    lo_next = lo_reg + CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // memory, count table and handshake
    always_comb
    begin
        in_ready    = (state_reg == S_IDLE);
        res_valid   = (state_reg == S_FIN);
        mem_rd_en   = 1'b0;
        mem_rd_addr = {cidx_reg, lo_reg[IDX_W-1:0]};
        mem_wr_en   = 1'b0;
        mem_wr_addr = {cidx_reg, n_reg[IDX_W-1:0]};
        mem_wr_data = {iend_reg, pos_reg};
        cnt_wr_en   = 1'b0;
        cnt_wr_idx  = cidx_reg;
        cnt_wr_data = n_reg + CNT_W'(1);
        case (state_reg)
            S_START:
            begin
                if (ok_reg && act_reg == ACT_LOAD)
                begin
                    if (n_reg == '0)
                    begin
                        mem_wr_en = 1'b1;
                        cnt_wr_en = 1'b1;
                    end
                    else
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = {cidx_reg, n_m1[IDX_W-1:0]};
                    end
                end
            end
            S_LCHK:
            begin
                if (!last_above && gap_after && !is_full)
                begin
                    mem_wr_en = 1'b1;
                    cnt_wr_en = 1'b1;
                end
                else if (!last_above && !gap_after && end_beyond)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = {cidx_reg, n_m1[IDX_W-1:0]};
                    mem_wr_data = {iend_reg, rd_start};
                end
            end
            S_BS:
            begin
                mem_rd_en   = lo_reg < hi_reg;
                mem_rd_addr = {cidx_reg, mid_calc[IDX_W-1:0]};
            end
            S_SRD:
            begin
                mem_rd_en = lo_reg < n_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg  <= action;
            ok_reg   <= chrom_ok;
            cidx_reg <= chrom_id[CIW-1:0];
            pos_reg  <= position_start;
            iend_reg <= island_end;
            rlen_reg <= read_length;
            n_reg    <= cnt_rd_data;
        end
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule
